[rtl/samr_pkg.sv]
// ----------------------------------------------------------------------------
// samr_pkg: shared types and codes for the address range resolver
// Item function codes, status codes, sequencer states and the best-candidate
// record passed to the compare unit.
// ----------------------------------------------------------------------------
package samr_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned IDX_OUT_W = 6;

  // Item function codes
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_RESOLVE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_LOOK,
    ST_DREAD
  } samr_state_t;

  // Current best candidate during a scan
  typedef struct packed {
    logic              have;
    logic [ADDR_W-1:0] start;
  } samr_best_t;

endpackage

[rtl/samr_ram.sv]
// ----------------------------------------------------------------------------
// samr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data that holds its
// value when no read is issued.
// ----------------------------------------------------------------------------
module samr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/samr_match.sv]
// ----------------------------------------------------------------------------
// samr_match: range compare unit
// Checks one stored range against the address and against the best start
// seen so far. Shared by every step of a scan.
// ----------------------------------------------------------------------------
module samr_match (
  input  logic [samr_pkg::ADDR_W-1:0] addr,
  input  logic [samr_pkg::ADDR_W-1:0] start,
  input  logic [samr_pkg::ADDR_W-1:0] stop,
  input  samr_pkg::samr_best_t        best,
  output logic                        hit
);

  logic contain;
  logic better;

  // Start inclusive, end exclusive; an empty or inverted range never contains
  assign contain = (start <= addr) && (addr < stop);

  // Strictly higher start wins, so the lower slot keeps ties
  assign better = !best.have || (start > best.start);

  assign hit = contain && better;

endmodule

[rtl/stack_address_module_resolver_core.sv]
// ----------------------------------------------------------------------------
// stack_address_module_resolver_core: address range table and resolver
// Loads ranges one word at a time, resolves addresses to the containing range
// with the highest start and hands out dense indices in first-reference order.
// ----------------------------------------------------------------------------
// Timing: one item at a time. A load, clear or unused item puts its result
// into the output register from the execute state once the output is free.
// A resolve walks the loaded ranges one entry per cycle through the single
// read port of the range RAM and one shared compare unit, then, when a range
// matches, reads the dense-index RAM. A resolve against an empty table gives
// its result from the execute state without a scan. The input stays stalled
// until the result is in the output register, and the next word is accepted
// even while the previous result waits on the output; a result that cannot be
// written holds the sequencer at its last step. No clearing pass is needed
// after reset: slot marks live in the dense-index RAM and are rewritten each
// time a slot is loaded.
// ----------------------------------------------------------------------------
module stack_address_module_resolver_core #(
  parameter int unsigned MAX_RANGES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [63:0] range_start,
  input  logic [63:0] range_end,
  input  logic [63:0] code_address,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic        found,
  output logic [5:0]  table_index,
  output logic [5:0]  dense_index,
  output logic        first_reference,
  output logic [63:0] range_offset
);

  localparam int unsigned IDX_W = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned AW    = samr_pkg::ADDR_W;
  localparam int unsigned OW    = samr_pkg::IDX_OUT_W;
  localparam int unsigned EXT_W = IDX_W + OW;
  localparam int unsigned RNG_W = 2 * AW;
  localparam int unsigned DNS_W = IDX_W + 1;

  samr_pkg::samr_state_t state, state_next;

  // Control and item registers
  logic [CNT_W-1:0] range_count;
  logic [CNT_W-1:0] next_dense;
  logic [CNT_W-1:0] idx;
  logic [1:0]       op;
  logic [AW-1:0]    addr_q;
  logic [AW-1:0]    start_q;
  logic [AW-1:0]    end_q;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic             have;
  logic [IDX_W-1:0] best;
  logic [AW-1:0]    lead_start;

  // RAM ports
  logic             rng_we;
  logic             rng_re;
  logic [RNG_W-1:0] rng_rdata;
  logic             dns_we;
  logic             dns_re;
  logic [IDX_W-1:0] dns_waddr;
  logic [DNS_W-1:0] dns_wdata;
  logic [DNS_W-1:0] dns_rdata;

  // Sequencer actions
  logic             accept;
  logic             out_free;
  logic             full;
  logic             scan_start;
  logic             scan_last;
  logic             tbl_clear;
  logic             dense_bump;
  logic             hit;
  samr_pkg::samr_best_t best_rec;

  // Result to be captured
  logic             res_fire;
  logic             res_status;
  logic             res_found;
  logic [IDX_W-1:0] res_tidx;
  logic [IDX_W-1:0] res_didx;
  logic             res_first;
  logic [AW-1:0]    res_offset;
  logic [EXT_W-1:0] tidx_ext;
  logic [EXT_W-1:0] didx_ext;

  assign in_stall  = (state != samr_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign full      = (range_count >= CNT_W'(MAX_RANGES));
  assign scan_last = ((idx + CNT_W'(1)) == range_count);

  // Range table: {end, start} per slot
  samr_ram #(
    .WIDTH (RNG_W),
    .DEPTH (MAX_RANGES)
  ) u_rng_ram (
    .clk     (clk),
    .we      (rng_we),
    .wr_addr (range_count[IDX_W-1:0]),
    .wr_data ({end_q, start_q}),
    .rd_en   (rng_re),
    .rd_addr (idx[IDX_W-1:0]),
    .rd_data (rng_rdata)
  );

  // Dense map: {referenced mark, dense index} per slot
  samr_ram #(
    .WIDTH (DNS_W),
    .DEPTH (MAX_RANGES)
  ) u_dns_ram (
    .clk     (clk),
    .we      (dns_we),
    .wr_addr (dns_waddr),
    .wr_data (dns_wdata),
    .rd_en   (dns_re),
    .rd_addr (best),
    .rd_data (dns_rdata)
  );

  // Shared compare unit
  assign best_rec.have  = have;
  assign best_rec.start = lead_start;

  samr_match u_match (
    .addr  (addr_q),
    .start (rng_rdata[AW-1:0]),
    .stop  (rng_rdata[RNG_W-1:AW]),
    .best  (best_rec),
    .hit   (hit)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      samr_pkg::ST_IDLE: begin
        if (accept) state_next = samr_pkg::ST_EXEC;
      end
      samr_pkg::ST_EXEC: begin
        if (op == samr_pkg::FUNC_RESOLVE && range_count != '0) begin
          state_next = samr_pkg::ST_SCAN;
        end else if (out_free) begin
          state_next = samr_pkg::ST_IDLE;
        end
      end
      samr_pkg::ST_SCAN: begin
        if (scan_last) state_next = samr_pkg::ST_DRAIN;
      end
      samr_pkg::ST_DRAIN: begin
        state_next = samr_pkg::ST_LOOK;
      end
      samr_pkg::ST_LOOK: begin
        if (have) begin
          state_next = samr_pkg::ST_DREAD;
        end else if (out_free) begin
          state_next = samr_pkg::ST_IDLE;
        end
      end
      samr_pkg::ST_DREAD: begin
        if (out_free) state_next = samr_pkg::ST_IDLE;
      end
      default: state_next = samr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    rng_we     = 1'b0;
    rng_re     = 1'b0;
    dns_we     = 1'b0;
    dns_re     = 1'b0;
    dns_waddr  = range_count[IDX_W-1:0];
    dns_wdata  = '0;
    scan_start = 1'b0;
    tbl_clear  = 1'b0;
    dense_bump = 1'b0;
    res_fire   = 1'b0;
    res_status = samr_pkg::STATUS_OK;
    res_found  = 1'b0;
    res_tidx   = '0;
    res_didx   = '0;
    res_first  = 1'b0;
    res_offset = '0;
    case (state)
      samr_pkg::ST_EXEC: begin
        case (op)
          samr_pkg::FUNC_LOAD: begin
            if (out_free) begin
              res_fire = 1'b1;
              if (full) begin
                res_status = samr_pkg::STATUS_FULL;
              end else begin
                // new slot starts unreferenced
                rng_we = 1'b1;
                dns_we = 1'b1;
              end
            end
          end
          samr_pkg::FUNC_CLEAR: begin
            if (out_free) begin
              res_fire  = 1'b1;
              tbl_clear = 1'b1;
            end
          end
          samr_pkg::FUNC_RESOLVE: begin
            if (range_count != '0) begin
              scan_start = 1'b1;
            end else if (out_free) begin
              res_fire = 1'b1;
            end
          end
          default: begin
            if (out_free) res_fire = 1'b1;
          end
        endcase
      end
      samr_pkg::ST_SCAN: begin
        rng_re = 1'b1;
      end
      samr_pkg::ST_LOOK: begin
        if (have) begin
          dns_re = 1'b1;
        end else if (out_free) begin
          res_fire = 1'b1;
        end
      end
      samr_pkg::ST_DREAD: begin
        if (out_free) begin
          res_fire   = 1'b1;
          res_found  = 1'b1;
          res_tidx   = best;
          res_offset = addr_q - lead_start;
          if (!dns_rdata[IDX_W]) begin
            // first hit on this slot: hand out the next dense index
            dns_we     = 1'b1;
            dns_waddr  = best;
            dns_wdata  = {1'b1, next_dense[IDX_W-1:0]};
            dense_bump = 1'b1;
            res_first  = 1'b1;
            res_didx   = next_dense[IDX_W-1:0];
          end else begin
            res_didx = dns_rdata[IDX_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= samr_pkg::ST_IDLE;
      range_count <= '0;
      next_dense  <= '0;
      pend        <= 1'b0;
      have        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == samr_pkg::ST_SCAN);
      if (tbl_clear) begin
        range_count <= '0;
        next_dense  <= '0;
      end else begin
        if (rng_we) range_count <= range_count + CNT_W'(1);
        if (dense_bump) next_dense <= next_dense + CNT_W'(1);
      end
      if (scan_start) begin
        have <= 1'b0;
      end else if (pend && hit) begin
        have <= 1'b1;
      end
      if (res_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item capture, scan walk and best candidate
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= func;
      start_q <= range_start;
      end_q   <= range_end;
      addr_q  <= code_address;
    end
    if (scan_start) begin
      idx <= '0;
    end else if (state == samr_pkg::ST_SCAN) begin
      idx <= idx + CNT_W'(1);
    end
    pend_idx <= idx[IDX_W-1:0];
    if (pend && hit) begin
      best       <= pend_idx;
      lead_start <= rng_rdata[AW-1:0];
    end
  end

  // Output register
  assign tidx_ext = EXT_W'(res_tidx);
  assign didx_ext = EXT_W'(res_didx);

  always_ff @(posedge clk) begin
    if (res_fire) begin
      status          <= res_status;
      found           <= res_found;
      table_index     <= tidx_ext[OW-1:0];
      dense_index     <= didx_ext[OW-1:0];
      first_reference <= res_first;
      range_offset    <= res_offset;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    range_count <= CNT_W'(MAX_RANGES))
    else $error("range count above table depth");

  a_dense_bound: assert property (@(posedge clk) disable iff (rst)
    next_dense <= range_count)
    else $error("more dense indices than loaded ranges");

  a_scan_in_table: assert property (@(posedge clk) disable iff (rst)
    state == samr_pkg::ST_SCAN |-> idx < range_count)
    else $error("scan beyond loaded ranges");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_fire |-> out_free)
    else $error("result written over a waiting word");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == samr_pkg::STATUS_OK)
    else $error("match result with reject status");

  a_first_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_reference |-> found)
    else $error("first reference without a match");

endmodule
